[design/bcse_pkg.sv]
// ---------------------------------------------------------------------------
// bcse_pkg: shared types and constants for the batch schedule evaluator
// Holds field widths, the transaction structs, policy and register codes,
// the sequencer state encoding and the control bundle for the eval unit.
// ---------------------------------------------------------------------------
package bcse_pkg;

   localparam int BURST_W     = 16;
   localparam int PRIO_W      = 8;
   localparam int JOBNUM_W    = 5;
   localparam int TIME_W      = 20;
   localparam int POLICY_W    = 2;
   localparam int SLICE_W     = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // one restoring division step per burst bit
   localparam int DIV_STEPS   = BURST_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [TIME_W-1:0]  TIME_MAX    = 20'hFFFFF;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd4;

   typedef enum logic [POLICY_W-1:0] {
      POLICY_FCFS     = 2'd0,
      POLICY_SJF      = 2'd1,
      POLICY_PRIORITY = 2'd2,
      POLICY_RR       = 2'd3
   } policy_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLICY = 4'd0,
      CSR_SLICE  = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst_length;
      logic [PRIO_W-1:0]  job_priority;
      logic               last_job;
   } req_type;

   typedef struct packed {
      logic [JOBNUM_W-1:0] job_number;
      logic [TIME_W-1:0]   wait_total;
      logic [TIME_W-1:0]   turnaround_total;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  priority_num;
   } job_entry_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD_KEY,
      OP_DIV_STEP,
      OP_BOUND,
      OP_ACCUM
   } unit_op_type;

   typedef struct packed {
      unit_op_type op;
      policy_type  policy;
      logic        j_le_k;
   } unit_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_LATCH,
      ST_DIVIDE,
      ST_BOUND,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

[design/bcse_job_store.sv]
// ---------------------------------------------------------------------------
// bcse_job_store: job table memory
// One write port for loading jobs, one read port with registered data for
// the evaluation scan.
// ---------------------------------------------------------------------------
module bcse_job_store
   import bcse_pkg::*;
#(
   parameter int MAX_PROCS = 16,
   parameter int IDX_W     = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  job_entry_type wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output job_entry_type rd_data
);

   job_entry_type mem [MAX_PROCS];
   job_entry_type rd_data_ff;

   // store a loaded job
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bcse_eval_unit.sv]
// ---------------------------------------------------------------------------
// bcse_eval_unit: shared compare / add unit
// Latches the job under evaluation, runs a bit-serial remainder of its burst
// by the slice, forms the round robin bounds and accumulates the completion
// time one scanned job per cycle.
// ---------------------------------------------------------------------------
module bcse_eval_unit
   import bcse_pkg::*;
#(
   parameter int ACC_W = 20
) (
   input  logic               clock,
   input  unit_ctrl_type      ctrl,
   input  logic [SLICE_W-1:0] slice,
   input  job_entry_type      entry,
   output logic [TIME_W-1:0]  wait_total,
   output logic [TIME_W-1:0]  turnaround_total
);

   localparam int WIDE_W = ACC_W + TIME_W;

   logic [BURST_W-1:0] bk_ff, bk_in;
   logic [PRIO_W-1:0]  pk_ff, pk_in;
   logic [BURST_W-1:0] dvd_ff, dvd_in;
   logic [BURST_W-1:0] rem_ff, rem_in;
   logic [BURST_W:0]   hi_ff, hi_in;
   logic [BURST_W:0]   lo_ff, lo_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   logic [SLICE_W-1:0] q_eff;
   logic [BURST_W:0]   trial;
   logic [BURST_W:0]   trial_sub;
   logic [BURST_W:0]   bj_ext;
   logic [BURST_W:0]   cap;
   logic [BURST_W:0]   rr_add;
   logic [BURST_W:0]   add_val;
   logic               take;
   logic [WIDE_W-1:0]  turn_wide;
   logic [WIDE_W-1:0]  wait_wide;

   // a zero slice acts as one
   assign q_eff = (slice == '0) ? SLICE_W'(1) : slice;

   always_comb begin
      bk_in  = bk_ff;
      pk_in  = pk_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      acc_in = acc_ff;

      // restoring division step
      trial     = {rem_ff, dvd_ff[BURST_W-1]};
      trial_sub = trial - {1'b0, q_eff};

      // contribution of the scanned job
      bj_ext = {1'b0, entry.burst};
      cap    = ctrl.j_le_k ? hi_ff : lo_ff;
      rr_add = (bj_ext < cap) ? bj_ext : cap;
      case (ctrl.policy)
         POLICY_FCFS: take = ctrl.j_le_k;
         POLICY_SJF: take = (entry.burst < bk_ff) ||
                            ((entry.burst == bk_ff) && ctrl.j_le_k);
         POLICY_PRIORITY: take = (entry.priority_num < pk_ff) ||
                                 ((entry.priority_num == pk_ff) && ctrl.j_le_k);
         default: take = 1'b1;
      endcase
      if (ctrl.policy == POLICY_RR) begin
         add_val = rr_add;
      end else begin
         add_val = take ? bj_ext : '0;
      end

      case (ctrl.op)
         OP_LOAD_KEY: begin
            bk_in  = entry.burst;
            pk_in  = entry.priority_num;
            dvd_in = entry.burst;
            rem_in = '0;
            acc_in = '0;
         end
         OP_DIV_STEP: begin
            dvd_in = {dvd_ff[BURST_W-2:0], 1'b0};
            if (trial >= {1'b0, q_eff}) begin
               rem_in = trial_sub[BURST_W-1:0];
            end else begin
               rem_in = trial[BURST_W-1:0];
            end
         end
         OP_BOUND: begin
            // hi: burst rounded up to whole slices (at least one), lo: hi less a slice
            if (bk_ff == '0) begin
               hi_in = {1'b0, q_eff};
               lo_in = '0;
            end else if (rem_ff == '0) begin
               hi_in = {1'b0, bk_ff};
               lo_in = {1'b0, bk_ff} - {1'b0, q_eff};
            end else begin
               hi_in = {1'b0, bk_ff} - {1'b0, rem_ff} + {1'b0, q_eff};
               lo_in = {1'b0, bk_ff} - {1'b0, rem_ff};
            end
         end
         OP_ACCUM: begin
            acc_in = acc_ff + ACC_W'(add_val);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bk_ff  <= bk_in;
      pk_ff  <= pk_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      acc_ff <= acc_in;
   end

   // saturate the reported times
   always_comb begin
      turn_wide = WIDE_W'(acc_ff);
      wait_wide = WIDE_W'(acc_ff) - WIDE_W'(bk_ff);
      turnaround_total = (turn_wide > WIDE_W'(TIME_MAX)) ? TIME_MAX
                                                         : turn_wide[TIME_W-1:0];
      wait_total       = (wait_wide > WIDE_W'(TIME_MAX)) ? TIME_MAX
                                                         : wait_wide[TIME_W-1:0];
   end

endmodule

[design/batch_cpu_schedule_evaluator_top.sv]
// ---------------------------------------------------------------------------
// batch_cpu_schedule_evaluator_top: batch CPU schedule evaluator
// Loads a batch of jobs and reports waiting and turnaround times under
// FCFS, shortest job, priority or round robin scheduling.
// ---------------------------------------------------------------------------
// Usage:
//   Load jobs with start while busy is low, one transaction per cycle. Jobs
//   past MAX_PROCS are dropped. A transaction with last_job set starts the
//   evaluation and raises busy until the final result has been sent.
//   Results come out in load order, each as a one-cycle rsp_valid strobe;
//   the receiver cannot stall them and must take every one.
//   Each job's completion time is found by one scan over the stored batch
//   through a single compare/add unit, preceded in round robin mode by the
//   bit-serial remainder of its burst by the slice and the slice bounds.
//   Loading runs at one job per cycle.
//   The CSR channel (csr_valid/csr_ready, index 0 policy, 1 slice) is
//   written between batches while busy is low.
//   Reset clears the batch, sets policy to FCFS and the slice to 4; the
//   job memory itself is not cleared.
// ---------------------------------------------------------------------------
module batch_cpu_schedule_evaluator_top
   import bcse_pkg::*;
#(
   parameter int MAX_PROCS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int ACC_W = BURST_W + CNT_W;
   localparam int NUM_W = CNT_W + JOBNUM_W;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [IDX_W-1:0]       jd_ff;
   logic                   acc_pending_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   policy_type             policy_ff;
   logic [SLICE_W-1:0]     slice_ff;

   logic                   accept;
   logic                   full;
   logic [CNT_W-1:0]       last_idx;
   logic                   k_last;
   logic                   j_last;
   logic [IDX_W-1:0]       rd_addr;
   job_entry_type          wr_entry;
   job_entry_type          rd_entry;
   unit_ctrl_type          ctrl;
   logic [TIME_W-1:0]      wait_val;
   logic [TIME_W-1:0]      turn_val;
   logic [NUM_W-1:0]       job_num_wide;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign full      = (count_ff == CNT_W'(MAX_PROCS));
   assign last_idx  = count_ff - CNT_W'(1);
   assign k_last    = (CNT_W'(k_ff) == last_idx);
   assign j_last    = (CNT_W'(j_ff) == last_idx);

   assign wr_entry.burst        = req_data.burst_length;
   assign wr_entry.priority_num = req_data.job_priority;

   bcse_job_store #(
      .MAX_PROCS(MAX_PROCS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (accept && !full),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   bcse_eval_unit #(
      .ACC_W(ACC_W)
   ) u_unit (
      .clock           (clock),
      .ctrl            (ctrl),
      .slice           (slice_ff),
      .entry           (rd_entry),
      .wait_total      (wait_val),
      .turnaround_total(turn_val)
   );

   // sequencer: next state and unit control
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      div_cnt_in = div_cnt_ff;
      rd_addr    = j_ff;
      ctrl.op    = OP_IDLE;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last_job) begin
                  k_in     = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            rd_addr  = k_ff;
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            ctrl.op    = OP_LOAD_KEY;
            j_in       = '0;
            div_cnt_in = '0;
            state_in   = (policy_ff == POLICY_RR) ? ST_DIVIDE : ST_SCAN;
         end
         ST_DIVIDE: begin
            ctrl.op    = OP_DIV_STEP;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            ctrl.op  = OP_BOUND;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr = j_ff;
            j_in    = j_ff + IDX_W'(1);
            if (j_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (k_last) begin
               count_in = '0;
               state_in = ST_LOAD;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      // read data arrives in the cycle after the scan address
      if (acc_pending_ff) begin
         ctrl.op = OP_ACCUM;
      end
      ctrl.policy = policy_ff;
      ctrl.j_le_k = (jd_ff <= k_ff);
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         k_ff           <= '0;
         j_ff           <= '0;
         div_cnt_ff     <= '0;
         acc_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         k_ff           <= k_in;
         j_ff           <= j_in;
         div_cnt_ff     <= div_cnt_in;
         acc_pending_ff <= (state_ff == ST_SCAN);
      end
   end

   // track the index of the job in flight
   always_ff @(posedge clock) begin
      jd_ff <= j_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FCFS;
         slice_ff  <= SLICE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_POLICY: policy_ff <= policy_type'(csr_wdata[POLICY_W-1:0]);
            CSR_SLICE:  slice_ff  <= csr_wdata[SLICE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // drive the result transaction
   always_comb begin
      job_num_wide              = NUM_W'(k_ff) + NUM_W'(1);
      rsp_data.job_number       = job_num_wide[JOBNUM_W-1:0];
      rsp_data.wait_total       = wait_val;
      rsp_data.turnaround_total = turn_val;
      rsp_data.last_result      = k_last;
   end

   // checks
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_last_starts_eval: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_job) |=> busy)
      else $error("last job did not start evaluation");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_data.last_job) |=> !busy)
      else $error("non-last job left load state");

   a_final_releases: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_result) |=> (!busy && count_ff == '0))
      else $error("batch not released after final result");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back result strobes");

endmodule
